@@ rtl/core/rtlu_pkg.sv @@
// rtlu_pkg: shared types, codes and defaults for the route table lookup unit
// no dependencies; imported by rtlu_ram users, rtlu_scan and the top level
package rtlu_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int PORT_COUNT_DEF  = 4;

	localparam int ACT_W    = 2;
	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] hop;
		logic [PORT_W-1:0] port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic start;   // clear trackers for a new request
		logic vld;     // read data of one entry is present
	} scan_ctl_t;

	typedef struct packed {
		logic              found;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] hop;
	} scan_res_t;

endpackage

@@ rtl/core/rtlu_ram.sv @@
// rtlu_ram: generic single-write, single-read synchronous RAM, registered read
// no dependencies
module rtlu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/rtlu_scan.sv @@
// rtlu_scan: per-entry evaluation during a table sweep, keeps the chosen slot
// depends on rtlu_pkg
module rtlu_scan #(
	parameter int TABLE_DEPTH = rtlu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rtlu_pkg::scan_ctl_t            ctl,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_idx,
	input  rtlu_pkg::entry_t               rd_data,
	input  logic [rtlu_pkg::ACT_W-1:0]     action,
	input  logic [rtlu_pkg::ADDR_W-1:0]    dest_addr,
	input  logic [rtlu_pkg::ADDR_W-1:0]    route_mask,
	input  logic [rtlu_pkg::ADDR_W-1:0]    hop_addr,
	output rtlu_pkg::scan_res_t            res,
	output logic [$clog2(TABLE_DEPTH)-1:0] slot
);
	import rtlu_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic              found_q;
	logic [ADDR_W-1:0] best_mask_q;
	logic [PORT_W-1:0] port_q;
	logic [ADDR_W-1:0] hop_q;
	logic [IDX_W-1:0]  slot_q;
	logic              take;

	always_comb begin
		take = 1'b0;
		unique case (action)
			ACT_LOOKUP: begin
				// ranked by mask value, later slot wins a tie
				take = rd_data.valid && ((dest_addr & rd_data.mask) == rd_data.prefix)
					&& (!found_q || (rd_data.mask >= best_mask_q));
			end
			ACT_ADD: begin
				take = !rd_data.valid && !found_q;
			end
			ACT_DELETE: begin
				take = rd_data.valid && !found_q && (rd_data.prefix == dest_addr)
					&& (rd_data.mask == route_mask) && (rd_data.hop == hop_addr);
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (ctl.vld && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld && take && !ctl.start) begin
			best_mask_q <= rd_data.mask;
			port_q      <= rd_data.port;
			hop_q       <= (rd_data.hop == '0) ? dest_addr : rd_data.hop;
			slot_q      <= rd_idx;
		end
	end

	assign res.found = found_q;
	assign res.port  = port_q;
	assign res.hop   = hop_q;
	assign slot      = slot_q;

endmodule

@@ rtl/core/ipv4_route_table_lookup_unit.sv @@
// ipv4_route_table_lookup_unit: longest-mask route table, one entry RAM swept
// per request; depends on rtlu_pkg, rtlu_ram, rtlu_scan
// requests: a new beat is accepted only in idle, after the previous result has
//   been committed (commit waits while out_stall holds a result); the entry sweep
//   runs through the single read port of the table RAM, one entry a cycle
// reset: after arst_n the table RAM is cleared entry by entry, no beat is accepted
//   meanwhile
module ipv4_route_table_lookup_unit #(
	parameter int TABLE_DEPTH = rtlu_pkg::TABLE_DEPTH_DEF,
	parameter int PORT_COUNT  = rtlu_pkg::PORT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rtlu_pkg::ACT_W-1:0]    action,
	input  logic [rtlu_pkg::ADDR_W-1:0]   dest_addr,
	input  logic [rtlu_pkg::ADDR_W-1:0]   route_mask,
	input  logic [rtlu_pkg::ADDR_W-1:0]   hop_addr,
	input  logic [rtlu_pkg::PORT_W-1:0]   port,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rtlu_pkg::STATUS_W-1:0] status,
	output logic [rtlu_pkg::PORT_W-1:0]   out_port,
	output logic [rtlu_pkg::ADDR_W-1:0]   next_hop
);
	import rtlu_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;

	logic [ACT_W-1:0]    act_q;
	logic [ADDR_W-1:0]   dest_q;
	logic [ADDR_W-1:0]   mask_q;
	logic [ADDR_W-1:0]   hop_q;
	logic [PORT_W-1:0]   port_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [PORT_W-1:0]   out_port_q;
	logic [ADDR_W-1:0]   next_hop_q;

	logic                accept;
	logic                out_free;
	logic                commit;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	entry_t              ram_wdata;
	entry_t              ram_rdata;
	entry_t              new_entry;
	logic [PORT_W-1:0]   sat_port;
	scan_ctl_t           scan_ctl;
	scan_res_t           scan_res;
	logic [IDX_W-1:0]    scan_slot;
	logic [STATUS_W-1:0] status_d;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == S_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			act_q  <= action;
			dest_q <= dest_addr;
			mask_q <= route_mask;
			hop_q  <= hop_addr;
			port_q <= port;
		end
	end

	always_comb begin
		if (int'(port_q) > PORT_COUNT - 1) begin
			sat_port = PORT_W'(PORT_COUNT - 1);
		end else begin
			sat_port = port_q;
		end
		new_entry.valid  = 1'b1;
		new_entry.prefix = dest_q;
		new_entry.mask   = mask_q;
		new_entry.hop    = hop_q;
		new_entry.port   = sat_port;
	end

	// clear sweep, add fills the free slot, delete drops the valid bit
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = scan_slot;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
		end else if (commit && scan_res.found) begin
			if (act_q == ACT_ADD) begin
				ram_we    = 1'b1;
				ram_wdata = new_entry;
			end else if (act_q == ACT_DELETE) begin
				ram_we = 1'b1;
			end
		end
	end

	rtlu_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign scan_ctl.start = accept;
	assign scan_ctl.vld   = rd_vld_s1;

	rtlu_scan #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.rd_idx    (rd_idx_s1),
		.rd_data   (ram_rdata),
		.action    (act_q),
		.dest_addr (dest_q),
		.route_mask(mask_q),
		.hop_addr  (hop_q),
		.res       (scan_res),
		.slot      (scan_slot)
	);

	always_comb begin
		unique case (act_q)
			ACT_LOOKUP: status_d = scan_res.found ? ST_OK : ST_NO_ROUTE;
			ACT_ADD:    status_d = scan_res.found ? ST_OK : ST_FULL;
			ACT_DELETE: status_d = scan_res.found ? ST_OK : ST_ABSENT;
			default:    status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			if ((act_q == ACT_LOOKUP) && scan_res.found) begin
				out_port_q <= scan_res.port;
				next_hop_q <= scan_res.hop;
			end else begin
				out_port_q <= '0;
				next_hop_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_port  = out_port_q;
	assign next_hop  = next_hop_q;

endmodule

@@ test/ipv4_route_table_lookup_unit_tb.sv @@
`timescale 1ns / 100ps
// ipv4_route_table_lookup_unit_tb: checks route add, delete and longest-mask lookup
// against a behavioral table kept in the bench; depends on rtlu_pkg and the unit
module ipv4_route_table_lookup_unit_tb;
	import rtlu_pkg::*;

	localparam int ROUTE_SLOTS = TABLE_DEPTH_DEF;
	localparam int PORT_LIMIT  = PORT_COUNT_DEF;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] hop;
		logic [PORT_W-1:0] port;
	} route_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PORT_W-1:0]   out_port;
		logic [ADDR_W-1:0]   next_hop;
	} route_answer_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [ACT_W-1:0]    action     = ACT_LOOKUP;
	logic [ADDR_W-1:0]   dest_addr  = '0;
	logic [ADDR_W-1:0]   route_mask = '0;
	logic [ADDR_W-1:0]   hop_addr   = '0;
	logic [PORT_W-1:0]   port       = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [PORT_W-1:0]   out_port;
	logic [ADDR_W-1:0]   next_hop;

	// bench copy of the route table
	logic              route_live [ROUTE_SLOTS] = '{default: 1'b0};
	logic [ADDR_W-1:0] route_pfx  [ROUTE_SLOTS] = '{default: '0};
	logic [ADDR_W-1:0] route_msk  [ROUTE_SLOTS] = '{default: '0};
	logic [ADDR_W-1:0] route_nh   [ROUTE_SLOTS] = '{default: '0};
	logic [PORT_W-1:0] route_op   [ROUTE_SLOTS] = '{default: '0};

	route_answer_t expected_answers[$];
	int idle_pct    = 0;
	int stall_pct   = 0;
	int fail_count  = 0;
	int cycle_count = 0;

	ipv4_route_table_lookup_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.dest_addr  (dest_addr),
		.route_mask (route_mask),
		.hop_addr   (hop_addr),
		.port       (port),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_port   (out_port),
		.next_hop   (next_hop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ipv4_route_table_lookup_unit_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic route_req_t mk_req(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] d,
			logic [ADDR_W-1:0] m, logic [ADDR_W-1:0] h, logic [PORT_W-1:0] p);
		route_req_t r;
		r.action = act;
		r.dest   = d;
		r.mask   = m;
		r.hop    = h;
		r.port   = p;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] prefix_mask(int len);
		return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
	endfunction

	function automatic int pick_live_slot();
		int start;
		start = $urandom_range(ROUTE_SLOTS - 1);
		for (int i = 0; i < ROUTE_SLOTS; i++)
			if (route_live[(start + i) % ROUTE_SLOTS])
				return (start + i) % ROUTE_SLOTS;
		return -1;
	endfunction

	// longest mask wins, ties to the highest slot; updates the bench table
	function automatic route_answer_t predict_route_request(route_req_t req);
		route_answer_t     ans;
		logic              hit;
		logic              done;
		logic [ADDR_W-1:0] best_mask;
		logic [PORT_W-1:0] stored_port;
		ans = '0;
		hit = 1'b0;
		done = 1'b0;
		best_mask = '0;
		case (req.action)
			ACT_LOOKUP: begin
				ans.status = ST_NO_ROUTE;
				for (int s = 0; s < ROUTE_SLOTS; s++) begin
					if (route_live[s] && (req.dest & route_msk[s]) == route_pfx[s] &&
							(!hit || route_msk[s] >= best_mask)) begin
						hit = 1'b1;
						best_mask = route_msk[s];
						ans.status = ST_OK;
						ans.out_port = route_op[s];
						ans.next_hop = (route_nh[s] == '0) ? req.dest : route_nh[s];
					end
				end
			end
			ACT_ADD: begin
				ans.status = ST_FULL;
				stored_port = (req.port > PORT_LIMIT - 1) ? PORT_W'(PORT_LIMIT - 1) : req.port;
				for (int s = 0; s < ROUTE_SLOTS; s++) begin
					if (!done && !route_live[s]) begin
						done = 1'b1;
						route_live[s] = 1'b1;
						route_pfx[s] = req.dest;
						route_msk[s] = req.mask;
						route_nh[s] = req.hop;
						route_op[s] = stored_port;
						ans.status = ST_OK;
					end
				end
			end
			ACT_DELETE: begin
				ans.status = ST_ABSENT;
				for (int s = 0; s < ROUTE_SLOTS; s++) begin
					if (!done && route_live[s] && route_pfx[s] == req.dest &&
							route_msk[s] == req.mask && route_nh[s] == req.hop) begin
						done = 1'b1;
						route_live[s] = 1'b0;
						ans.status = ST_OK;
					end
				end
			end
			default: begin
				ans.status = ST_OK;
			end
		endcase
		return ans;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	// one request beat; the expectation is queued when the beat is taken
	task automatic send_request(input route_req_t req);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ROUTE_SLOTS + 8)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= req.action;
		dest_addr  <= req.dest;
		route_mask <= req.mask;
		hop_addr   <= req.hop;
		port       <= req.port;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_answers.push_back(predict_route_request(req));
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : answer_check
		route_answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				note_failure($sformatf("unexpected result status %0d port %0d hop %h",
					status, out_port, next_hop));
			end else begin
				want = expected_answers.pop_front();
				if (status !== want.status || out_port !== want.out_port ||
						next_hop !== want.next_hop)
					note_failure($sformatf(
						"expected status %0d port %0d hop %h, got status %0d port %0d hop %h",
						want.status, want.out_port, want.next_hop, status, out_port, next_hop));
			end
		end
	end

	task automatic test_basic_routes();
		send_request(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0, 2'd0));
		send_request(mk_req(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 2'd1));
		send_request(mk_req(ACT_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 2'd2));
		send_request(mk_req(ACT_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0101, 2'd3));
		send_request(mk_req(ACT_LOOKUP, 32'h0A01_0203, '0, '0, 2'd0));
		// direct route hands back the destination
		send_request(mk_req(ACT_LOOKUP, 32'h0A02_0304, '0, '0, 2'd0));
		send_request(mk_req(ACT_LOOKUP, 32'hC0A8_0001, '0, '0, 2'd0));
		// duplicate entry, equal masks so the higher slot wins
		send_request(mk_req(ACT_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0202, 2'd0));
		send_request(mk_req(ACT_LOOKUP, 32'h0A01_09FF, '0, '0, 2'd0));
	endtask

	task automatic test_odd_routes();
		// prefix with bits outside its mask never matches a lookup
		send_request(mk_req(ACT_ADD, 32'h0A00_00FF, 32'hFFFF_FF00, 32'h0102_0304, 2'd1));
		send_request(mk_req(ACT_LOOKUP, 32'h0A00_00FF, '0, '0, 2'd0));
		// non-contiguous mask ranks by its numeric value
		send_request(mk_req(ACT_ADD, 32'h1200_3400, 32'hFF00_FF00, 32'hFFFF_FFFF, 2'd3));
		send_request(mk_req(ACT_LOOKUP, 32'h12AB_34CD, '0, '0, 2'd0));
		send_request(mk_req(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
		send_request(mk_req(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0, 2'd0));
		send_request(mk_req(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
		send_request(mk_req(ACT_DELETE, 32'h0A00_00FF, 32'hFFFF_FF00, 32'h0102_0304, 2'd0));
		send_request(mk_req(ACT_DELETE, 32'h0A00_00FF, 32'hFFFF_FF00, 32'h0102_0304, 2'd0));
		send_request(mk_req(ACT_DELETE, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0101, 2'd0));
		send_request(mk_req(ACT_LOOKUP, 32'h0A01_0203, '0, '0, 2'd0));
	endtask

	task automatic test_table_full();
		logic [ADDR_W-1:0] m;
		while (pick_live_slot() < 0 || route_live.sum() with (int'(item)) < ROUTE_SLOTS) begin
			m = prefix_mask($urandom_range(8, 32));
			send_request(mk_req(ACT_ADD, $urandom & m, m, $urandom,
				PORT_W'($urandom_range(3))));
		end
		send_request(mk_req(ACT_ADD, 32'h0102_0300, 32'hFFFF_FF00, 32'h0, 2'd2));
	endtask

	task automatic test_random_traffic(input int beats, input int idle, input int stall);
		route_req_t        req;
		int                pick;
		int                live;
		int                slot;
		logic [ADDR_W-1:0] m;
		idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < beats; n++) begin
			live = route_live.sum() with (int'(item));
			slot = pick_live_slot();
			pick = $urandom_range(99);
			// keep the table fill moving between empty and full
			if (live >= ROUTE_SLOTS - 2 && pick >= 50 && pick < 75 && $urandom_range(1))
				pick = 80;
			if (live <= 2 && pick >= 75 && pick < 90)
				pick = 60;
			req = mk_req(ACT_LOOKUP, $urandom, $urandom, $urandom,
				PORT_W'($urandom_range(3)));
			if (pick < 40) begin
				if (slot >= 0)
					req.dest = (route_pfx[slot] & route_msk[slot]) | ($urandom & ~route_msk[slot]);
			end else if (pick < 50) begin
				// lookup of a random address
			end else if (pick < 75) begin
				req.action = ACT_ADD;
				m = prefix_mask($urandom_range(32));
				if (slot >= 0 && $urandom_range(1))
					req.dest = (route_pfx[slot] | ($urandom & ~route_msk[slot])) & m;
				else
					req.dest = $urandom & m;
				req.mask = m;
				req.hop = ($urandom_range(3) == 0) ? '0 : ADDR_W'($urandom);
			end else if (pick < 90) begin
				req.action = ACT_DELETE;
				if (slot >= 0) begin
					req.dest = route_pfx[slot];
					req.mask = route_msk[slot];
					req.hop = route_nh[slot];
				end
			end else if (pick < 96) begin
				// near miss on one field of a live entry
				req.action = ACT_DELETE;
				if (slot >= 0) begin
					req.dest = route_pfx[slot];
					req.mask = route_msk[slot];
					req.hop = route_nh[slot];
					case ($urandom_range(2))
						0: req.dest[$urandom_range(31)] ^= 1'b1;
						1: req.mask[$urandom_range(31)] ^= 1'b1;
						default: req.hop[$urandom_range(31)] ^= 1'b1;
					endcase
				end
			end else if (pick < 98) begin
				req.action = ACT_ADD;
			end else begin
				req.action = ACT_UNUSED;
			end
			send_request(req);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_routes();
		test_odd_routes();
		test_table_full();
		test_random_traffic(400, 0, 0);
		wait_until_drained();
		test_random_traffic(380, 68, 0);
		wait_until_drained();
		test_random_traffic(380, 0, 68);
		wait_until_drained();
		test_random_traffic(380, 28, 28);
		wait_until_drained();
		repeat (ROUTE_SLOTS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("ipv4_route_table_lookup_unit_tb passed");
		else
			$display("ipv4_route_table_lookup_unit_tb failed");
		$finish;
	end

endmodule
